FILE: hw/rtl/ssdp_pkg.sv
package ssdp_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_APPEND    = 3'd0,
        KIND_PREPEND   = 3'd1,
        KIND_DEL_LAST  = 3'd2,
        KIND_DEL_FIRST = 3'd3,
        KIND_PURGE     = 3'd4,
        KIND_READ      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  hi;
        logic [63:0] lo;
    } entry_t;

    typedef struct packed {
        logic             shl;
        logic             shr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
    } cell_cmd_t;

    // clear every byte after the first zero byte
    function automatic entry_t canon(input logic [63:0] lo, input logic [7:0] hi);
        entry_t res;
        logic   alive;
        res   = '0;
        alive = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            if (lo[8*b +: 8] == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                res.lo[8*b +: 8] = lo[8*b +: 8];
            end
        end
        if (alive)
        begin
            res.hi = hi;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/ssdp_if.sv
interface ssdp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] text_low;
    logic [7:0]  text_high;
    logic [3:0]  position;

    modport source (output valid, kind, text_low, text_high, position, input ready);
    modport sink (input valid, kind, text_low, text_high, position, output ready);
endinterface

interface ssdp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  entry_total;
    logic [4:0]  removed_total;
    logic [63:0] read_low;
    logic [7:0]  read_high;

    modport source (output valid, status, entry_total, removed_total, read_low, read_high,
                    input ready);
    modport sink (input valid, status, entry_total, removed_total, read_low, read_high,
                  output ready);
endinterface

FILE: hw/rtl/ssdp_cell.sv
module ssdp_cell
    import ssdp_pkg::*;
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] idx,
    input  entry_t           left_data,
    input  entry_t           right_data,
    output entry_t           data
);

    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.wr_en && (cmd.wr_idx == idx))
        begin
            data_next = cmd.wr_data;
        end
        else if (cmd.shl)
        begin
            data_next = right_data;
        end
        else if (cmd.shr)
        begin
            data_next = left_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/short_string_deque_with_purge_top.sv
// result: valid in the cycle after the accepted beat for append, prepend, deletes and read
// purge: one stored entry compared and moved per cycle, matches dropped and the rest kept in order
// throughput: one beat per cycle while results are taken, except purge, which holds input until its walk ends
// reset: entry count, purge state and handshake state clear; cell contents are not cleared
module short_string_deque_with_purge_top
    import ssdp_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    ssdp_req_if.sink     req,
    ssdp_rsp_if.source   rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_PURGE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    entry_t           key_reg, key_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [4:0]       total_reg, total_next;
    logic [4:0]       rm_reg, rm_next;
    entry_t           rdata_reg, rdata_next;

    cell_cmd_t        cmd;
    entry_t           cells [DEPTH];
    entry_t           in_key;
    logic             accept;
    logic [CNT_W-1:0] wr_pos;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign in_key    = canon(req.text_low, req.text_high);
    assign wr_pos    = rem_reg + kept_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        kept_next      = kept_reg;
        removed_next   = removed_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        total_next     = total_reg;
        rm_next        = rm_reg;
        rdata_next     = rdata_reg;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_DONE;
                    rm_next        = 5'd0;
                    rdata_next     = '0;
                    case (kind_t'(req.kind))
                        KIND_APPEND:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_idx  = IDX_W'(count_reg);
                                cmd.wr_data = in_key;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_PREPEND:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cmd.shr     = 1'b1;
                                cmd.wr_en   = 1'b1;
                                cmd.wr_idx  = '0;
                                cmd.wr_data = in_key;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_DEL_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                rm_next    = 5'd1;
                            end
                        end
                        KIND_DEL_FIRST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.shl    = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                rm_next    = 5'd1;
                            end
                        end
                        KIND_PURGE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                key_next       = in_key;
                                rem_next       = count_reg;
                                kept_next      = '0;
                                removed_next   = '0;
                                state_next     = ST_PURGE;
                            end
                        end
                        KIND_READ:
                        begin
                            if (CNT_W'(req.position) >= count_reg)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                rdata_next = cells[IDX_W'(req.position)];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    total_next = 5'(count_next);
                end
            end
            ST_PURGE:
            begin
                cmd.shl     = 1'b1;
                cmd.wr_idx  = IDX_W'(wr_pos);
                cmd.wr_data = cells[0];
                if (cells[0] == key_reg)
                begin
                    removed_next = removed_reg + CNT_W'(1);
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    kept_next = kept_reg + CNT_W'(1);
                end
                rem_next = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    count_next     = kept_next;
                    out_valid_next = 1'b1;
                    status_next    = STAT_DONE;
                    total_next     = 5'(kept_next);
                    rm_next        = 5'(removed_next);
                    rdata_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            kept_reg      <= '0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            status_reg    <= STAT_DONE;
            total_reg     <= '0;
            rm_reg        <= '0;
            rdata_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            kept_reg      <= kept_next;
            removed_reg   <= removed_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
            status_reg    <= status_next;
            total_reg     <= total_next;
            rm_reg        <= rm_next;
            rdata_reg     <= rdata_next;
        end
    end

    // row of cells, position 0 holds the first entry
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_data;
        entry_t right_data;
        if (i == 0)
        begin : g_first
            assign left_data = cmd.wr_data;
        end
        else
        begin : g_mid_l
            assign left_data = cells[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cells[i];
        end
        else
        begin : g_mid_r
            assign right_data = cells[i+1];
        end
        ssdp_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (IDX_W'(i)),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cells[i])
        );
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.entry_total   = total_reg;
    assign rsp.removed_total = rm_reg;
    assign rsp.read_low      = rdata_reg.lo;
    assign rsp.read_high     = rdata_reg.hi;

endmodule

FILE: sim/short_string_deque_with_purge_top_test.sv
`timescale 1ns / 1ps

module short_string_deque_with_purge_top_test;
    import ssdp_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [63:0] ONES_LOW = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] entry_total;
        logic [CNT_W-1:0] removed_total;
        logic [63:0]      read_low;
        logic [7:0]       read_high;
    } outcome_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] lo;
        logic [7:0]  hi;
        logic [3:0]  pos;
        logic        typed;
        outcome_t    want;
    } probe_t;

    localparam int PROBE_COUNT = 25;
    localparam probe_t PROBES [PROBE_COUNT] = '{
        '{kind: KIND_READ, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_RANGE, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_DEL_LAST, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_EMPTY, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_DEL_FIRST, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_EMPTY, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_PURGE, lo: ONES_LOW, hi: 8'hFF, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_EMPTY, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_SPARE_6, lo: ONES_LOW, hi: 8'hFF, pos: 4'hF, typed: 1'b1,
          want: '{status: STAT_DONE, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_SPARE_7, lo: ONES_LOW, hi: 8'hFF, pos: 4'hF, typed: 1'b1,
          want: '{status: STAT_DONE, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_APPEND, lo: ONES_LOW, hi: 8'hFF, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_DONE, entry_total: 5'd1, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_READ, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_DONE, entry_total: 5'd1, removed_total: 5'd0,
                  read_low: ONES_LOW, read_high: 8'hFF}},
        '{kind: KIND_PREPEND, lo: 64'hFFFF_FFFF_FFFF_0041, hi: 8'hAA, pos: 4'd0,
          typed: 1'b0, want: '0},
        '{kind: KIND_APPEND, lo: 64'd0, hi: 8'h5A, pos: 4'd0, typed: 1'b0, want: '0},
        '{kind: KIND_READ, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b0, want: '0},
        '{kind: KIND_READ, lo: 64'd0, hi: 8'd0, pos: 4'd2, typed: 1'b0, want: '0},
        '{kind: KIND_READ, lo: 64'd0, hi: 8'd0, pos: 4'hF, typed: 1'b1,
          want: '{status: STAT_RANGE, entry_total: 5'd3, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_APPEND, lo: 64'h4847_4645_4443_4241, hi: 8'd0, pos: 4'd0,
          typed: 1'b0, want: '0},
        '{kind: KIND_PREPEND, lo: 64'h0102_0304_0506_0708, hi: 8'h09, pos: 4'd0,
          typed: 1'b0, want: '0},
        '{kind: KIND_PURGE, lo: 64'h1234_5678_9ABC_0041, hi: 8'h77, pos: 4'd0,
          typed: 1'b0, want: '0},
        '{kind: KIND_PURGE, lo: 64'h0000_0000_0000_5A5A, hi: 8'd0, pos: 4'd0,
          typed: 1'b0, want: '0},
        '{kind: KIND_APPEND, lo: ONES_LOW, hi: 8'hFF, pos: 4'd0, typed: 1'b0, want: '0},
        '{kind: KIND_PURGE, lo: ONES_LOW, hi: 8'hFF, pos: 4'd0, typed: 1'b0, want: '0},
        '{kind: KIND_READ, lo: 64'd0, hi: 8'd0, pos: 4'd1, typed: 1'b0, want: '0},
        '{kind: KIND_DEL_FIRST, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b0, want: '0},
        '{kind: KIND_DEL_LAST, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b0, want: '0},
        '{kind: KIND_DEL_LAST, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b0, want: '0},
        '{kind: KIND_DEL_FIRST, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_EMPTY, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}},
        '{kind: KIND_PURGE, lo: 64'd0, hi: 8'd0, pos: 4'd0, typed: 1'b1,
          want: '{status: STAT_EMPTY, entry_total: 5'd0, removed_total: 5'd0,
                  read_low: 64'd0, read_high: 8'd0}}
    };

    logic clk;
    logic rst_n;

    ssdp_req_if req_bus();
    ssdp_rsp_if rsp_bus();

    short_string_deque_with_purge_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    entry_t   shelf [$];
    outcome_t pending_outcomes [$];
    outcome_t arrived;
    entry_t   word_pool [POOL_SIZE];
    int       word_len [POOL_SIZE];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;
    bit growing;
    int cycle_count;
    int mismatches;
    int beats_sent;
    int results_checked;
    int full_drops;
    int purged_entries;
    int read_hits;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // strip everything after the first zero byte
    function automatic entry_t trim_text(input logic [63:0] lo, input logic [7:0] hi);
        entry_t t;
        int     cut;
        t   = {hi, lo};
        cut = 9;
        for (int b = 8; b >= 0; b--)
        begin
            if (t[8*b +: 8] == 8'd0)
            begin
                cut = b;
            end
        end
        for (int b = 0; b < 9; b++)
        begin
            if (b >= cut)
            begin
                t[8*b +: 8] = 8'd0;
            end
        end
        return t;
    endfunction

    function automatic outcome_t apply_request(input logic [2:0] kind, input logic [63:0] lo,
                                               input logic [7:0] hi, input logic [3:0] pos);
        outcome_t r;
        entry_t   key;
        entry_t   survivors [$];
        r   = '0;
        key = trim_text(lo, hi);
        case (kind)
            KIND_APPEND, KIND_PREPEND:
            begin
                if (shelf.size() >= DEPTH)
                begin
                    r.status = STAT_FULL;
                    full_drops++;
                end
                else if (kind == KIND_APPEND)
                begin
                    shelf.push_back(key);
                end
                else
                begin
                    shelf.push_front(key);
                end
            end
            KIND_DEL_LAST, KIND_DEL_FIRST:
            begin
                if (shelf.size() == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    if (kind == KIND_DEL_LAST)
                    begin
                        void'(shelf.pop_back());
                    end
                    else
                    begin
                        void'(shelf.pop_front());
                    end
                    r.removed_total = CNT_W'(1);
                end
            end
            KIND_PURGE:
            begin
                if (shelf.size() == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    foreach (shelf[i])
                    begin
                        if (shelf[i] == key)
                        begin
                            r.removed_total++;
                        end
                        else
                        begin
                            survivors.push_back(shelf[i]);
                        end
                    end
                    shelf = survivors;
                    purged_entries += r.removed_total;
                end
            end
            KIND_READ:
            begin
                if (pos >= shelf.size())
                begin
                    r.status = STAT_RANGE;
                end
                else
                begin
                    r.read_low  = shelf[pos].lo;
                    r.read_high = shelf[pos].hi;
                    read_hits++;
                end
            end
            default:
            begin
            end
        endcase
        r.entry_total = CNT_W'(shelf.size());
        return r;
    endfunction

    // keep the string body, terminate it and fill the tail with junk
    function automatic entry_t dress_text(input entry_t body, input int len);
        entry_t raw;
        raw.lo = {$urandom, $urandom};
        raw.hi = 8'($urandom);
        for (int b = 0; b < 9; b++)
        begin
            if (b < len)
            begin
                raw[8*b +: 8] = body[8*b +: 8];
            end
            else if (b == len)
            begin
                raw[8*b +: 8] = 8'd0;
            end
        end
        return raw;
    endfunction

    task automatic push_request(input logic [2:0] kind, input logic [63:0] lo,
                                input logic [7:0] hi, input logic [3:0] pos,
                                input logic typed, input outcome_t want);
        outcome_t got;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.kind      <= kind;
        req_bus.text_low  <= lo;
        req_bus.text_high <= hi;
        req_bus.position  <= pos;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        got = apply_request(kind, lo, hi, pos);
        pending_outcomes.push_back(typed ? want : got);
        beats_sent++;
    endtask

    task automatic offer_random_request();
        logic [2:0] kind;
        entry_t     text;
        logic [3:0] pos;
        int         roll;
        int         pick;
        int         held;
        held = shelf.size();
        roll = $urandom_range(99);
        if (roll >= 98)
        begin
            kind = 3'($urandom_range(KIND_SPARE_6, KIND_SPARE_7));
        end
        else if (growing)
        begin
            kind = (roll < 45) ? KIND_APPEND : (roll < 70) ? KIND_PREPEND :
                   (roll < 75) ? KIND_DEL_LAST : (roll < 80) ? KIND_DEL_FIRST :
                   (roll < 88) ? KIND_PURGE : KIND_READ;
        end
        else
        begin
            kind = (roll < 15) ? KIND_APPEND : (roll < 25) ? KIND_PREPEND :
                   (roll < 45) ? KIND_DEL_LAST : (roll < 65) ? KIND_DEL_FIRST :
                   (roll < 80) ? KIND_PURGE : KIND_READ;
        end
        pick = $urandom_range(POOL_SIZE - 1);
        if ($urandom_range(7) == 0)
        begin
            text.lo = {$urandom, $urandom};
            text.hi = 8'($urandom);
        end
        else
        begin
            text = dress_text(word_pool[pick], word_len[pick]);
        end
        if ($urandom_range(3) != 0 && held > 0)
        begin
            pos = 4'($urandom_range(held - 1));
        end
        else
        begin
            pos = 4'($urandom_range(15));
        end
        push_request(kind, text.lo, text.hi, pos, 1'b0, '0);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                growing = 1'($urandom_range(1));
            end
            offer_random_request();
        end
    endtask

    task automatic wait_for_quiet();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_off--;
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                mismatches++;
            end
            else
            begin
                arrived = pending_outcomes.pop_front();
                results_checked++;
                if (rsp_bus.status !== arrived.status)
                begin
                    $error("status expected %0d actual %0d", arrived.status, rsp_bus.status);
                    mismatches++;
                end
                if (rsp_bus.entry_total !== arrived.entry_total)
                begin
                    $error("entry_total expected %0d actual %0d", arrived.entry_total,
                           rsp_bus.entry_total);
                    mismatches++;
                end
                if (rsp_bus.removed_total !== arrived.removed_total)
                begin
                    $error("removed_total expected %0d actual %0d", arrived.removed_total,
                           rsp_bus.removed_total);
                    mismatches++;
                end
                if (rsp_bus.read_low !== arrived.read_low)
                begin
                    $error("read_low expected %h actual %h", arrived.read_low,
                           rsp_bus.read_low);
                    mismatches++;
                end
                if (rsp_bus.read_high !== arrived.read_high)
                begin
                    $error("read_high expected %h actual %h", arrived.read_high,
                           rsp_bus.read_high);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("short_string_deque_with_purge_top_test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_bus.valid     = 1'b0;
        req_bus.kind      = KIND_APPEND;
        req_bus.text_low  = 64'd0;
        req_bus.text_high = 8'd0;
        req_bus.position  = 4'd0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        hold_off          = 0;
        growing           = 1'b1;
        cycle_count       = 0;
        mismatches        = 0;
        beats_sent        = 0;
        results_checked   = 0;
        full_drops        = 0;
        purged_entries    = 0;
        read_hits         = 0;

        // short strings of random length up to nine bytes, reused so that purges find matches
        for (int p = 0; p < POOL_SIZE; p++)
        begin
            word_pool[p] = '0;
            word_len[p]  = $urandom_range(9);
            for (int b = 0; b < 9; b++)
            begin
                if (b < word_len[p])
                begin
                    word_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
                end
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (PROBES[i])
        begin
            push_request(PROBES[i].kind, PROBES[i].lo, PROBES[i].hi, PROBES[i].pos,
                         PROBES[i].typed, PROBES[i].want);
        end
        wait_for_quiet();

        send_idle_pct = 26;
        recv_idle_pct = 63;
        run_random(120);
        // long receiver hold-off while the sender keeps pushing
        hold_off = 300;
        run_random(30);
        wait_for_quiet();
        run_random(120);
        wait_for_quiet();

        send_idle_pct = 63;
        recv_idle_pct = 26;
        run_random(240);
        wait_for_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(240);
        wait_for_quiet();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked in %0d cycles", beats_sent,
                 results_checked, cycle_count);
        $display("%0d full drops, %0d entries purged, %0d successful reads", full_drops,
                 purged_entries, read_hits);
        if (mismatches == 0)
        begin
            $display("short_string_deque_with_purge_top_test passed");
        end
        else
        begin
            $display("short_string_deque_with_purge_top_test failed");
        end
        $finish;
    end

endmodule
